### design/mtca_pkg.sv
// Shared types, codes and message tables for the MPE touch channel allocator.
package mtca_pkg;

  localparam int TOUCH_ID_BITS = 16;
  localparam int DIV_BITS      = 24;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_END    = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_CONFIG = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_OLDOFF,
    S_ALLOC,
    S_DSET,
    S_DIV,
    S_UPD,
    S_CLR,
    S_REL,
    S_CFG
  } state_t;

  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CTRL     = 8'hB0;
  localparam logic [7:0] ST_CTRL_UP  = 8'hBF;
  localparam logic [7:0] ST_PRESS    = 8'hD0;
  localparam logic [7:0] ST_BEND     = 8'hE0;

  localparam logic [7:0] CC_TIMBRE   = 8'd74;
  localparam logic [7:0] CC_MCM      = 8'h79;
  localparam logic [7:0] CC_RPN_LSB  = 8'h64;
  localparam logic [7:0] CC_RPN_MSB  = 8'h65;
  localparam logic [7:0] CC_DATA     = 8'h06;
  localparam logic [7:0] VEL_ON      = 8'd100;

  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_3 = 2'd3;

  localparam logic [4:0] CFG_LAST = 5'd13;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] len;
  } msg_t;

  // z * 127 >> 15, held to 127
  function automatic logic [6:0] sat127(input logic [15:0] v);
    logic [22:0] s;
    s = {v, 7'b0} - {7'b0, v};
    sat127 = (s[22:15] > 8'd127) ? 7'd127 : s[21:15];
  endfunction

  // Zone and bend range announcement, one message per step
  function automatic msg_t cfg_msg(input logic [4:0] idx, input logic [3:0] lzs,
                                   input logic [6:0] br);
    msg_t       m;
    logic [7:0] up;
    up = (lzs <= 4'd14) ? 8'(4'd14 - lzs) : 8'd0;
    m.len = LEN_3;
    m.status = ST_CTRL;
    m.d1 = CC_DATA;
    m.d2 = 8'd0;
    case (idx)
      5'd0:  begin m.d1 = CC_MCM; end
      5'd1:  begin m.d1 = CC_RPN_LSB; m.d2 = 8'd6; end
      5'd2:  begin m.d1 = CC_RPN_MSB; end
      5'd3:  begin m.d2 = {4'b0, lzs}; end
      5'd4:  begin m.status = ST_CTRL_UP; m.d1 = CC_MCM; end
      5'd5:  begin m.status = ST_CTRL_UP; m.d1 = CC_RPN_LSB; m.d2 = 8'd6; end
      5'd6:  begin m.status = ST_CTRL_UP; m.d1 = CC_RPN_MSB; end
      5'd7:  begin m.status = ST_CTRL_UP; m.d2 = up; end
      5'd8:  begin m.d1 = CC_RPN_LSB; end
      5'd9:  begin m.d1 = CC_RPN_MSB; end
      5'd10: begin m.d2 = {1'b0, br}; end
      5'd11: begin m.status = ST_CTRL_UP; m.d1 = CC_RPN_LSB; end
      5'd12: begin m.status = ST_CTRL_UP; m.d1 = CC_RPN_MSB; end
      default: begin m.status = ST_CTRL_UP; m.d2 = {1'b0, br}; end
    endcase
    cfg_msg = m;
  endfunction

endpackage

### design/mpe_touch_channel_allocator_unit.sv
// Top level of the MPE touch channel allocator: sequencer, channel table and divider.
//
// Channel | Handshake       | Payload
// in      | tvalid/tready   | tuser: command, zone; tdata: id, x, y, z, time tag
// out     | tvalid/tready   | tdata: status, data1, data2, length, time tag; tlast
// cfg     | APB write/read  | 0x0 lower zone size, 0x4 bend range
//
// One transaction at a time; in_tready is high only while the sequencer is idle.
// Begin takes a channel scan, a bit-serial divide of a 24-bit magnitude and then
// its messages; clear and send configuration scan all 16 channels, two messages
// per active channel, and send configuration adds 14 announcement messages.
// A stalled result holds the sequencer. Reset frees all channels and loads the
// register defaults.
module mpe_touch_channel_allocator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [3:0]   in_tuser,   // command[2:0], zone[3]
  input  logic [103:0] in_tdata,   // touch_id, pitch_position, modulation_position,
                                   // pressure_level, time_tag, zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // status_byte, first_data, second_data,
                                   // byte_count, out_time_tag, zero fill
  output logic         out_tlast,  // last_message
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import mtca_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0]  lzs_r;
  logic [6:0]  br_r;
  logic [15:0] active_r;
  logic [TOUCH_ID_BITS-1:0] touch_r [16];
  logic [6:0]  note_r [16];
  logic [3:0]  lptr_r, uptr_r;

  logic [2:0]  cmd_r;
  logic        zone_r;
  logic [TOUCH_ID_BITS-1:0] id_r;
  logic signed [16:0] x_r;
  logic [15:0] y_r, z_r;
  logic [31:0] tag_r;

  logic [3:0]  idx_r, ch_r;
  logic [4:0]  cnt_r;
  logic [DIV_BITS-1:0] m_r;
  logic [8:0]  rem_r;
  logic [7:0]  dvs_r;
  logic        neg_r;

  logic        out_valid_r;
  msg_t        omsg_r;
  logic [31:0] otag_r;
  logic        olast_r;

  // Command and zone decode
  logic [2:0]  in_cmd;
  logic        in_zone;
  logic [3:0]  zf, zl, in_zf;
  logic        zok, in_zok;
  logic        hit, can, emit;
  msg_t        emsg;
  logic        elast;

  assign in_cmd  = in_tuser[2:0];
  assign in_zone = in_tuser[3];

  always_comb begin
    zf     = zone_r ? lzs_r + 4'd1 : 4'd1;
    zl     = zone_r ? 4'd14 : lzs_r;
    zok    = zone_r ? (lzs_r < 4'd14) : (lzs_r != 4'd0);
    in_zf  = in_zone ? lzs_r + 4'd1 : 4'd1;
    in_zok = in_zone ? (lzs_r < 4'd14) : (lzs_r != 4'd0);
  end

  assign hit = active_r[idx_r] && (touch_r[idx_r] == id_r);
  assign can = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            CMD_BEGIN, CMD_UPDATE, CMD_END: state_nxt = in_zok ? S_FIND : S_IDLE;
            CMD_CLEAR, CMD_CONFIG:          state_nxt = S_CLR;
            default:                        state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (hit) begin
          case (cmd_r)
            CMD_BEGIN:  state_nxt = S_OLDOFF;
            CMD_UPDATE: state_nxt = S_DSET;
            default:    state_nxt = S_REL;
          endcase
        end else if (idx_r >= zl) begin
          state_nxt = (cmd_r == CMD_BEGIN) ? S_ALLOC : S_IDLE;
        end
      end
      S_OLDOFF: if (can) state_nxt = S_ALLOC;
      S_ALLOC:  state_nxt = S_DSET;
      S_DSET:   state_nxt = S_DIV;
      S_DIV:    if (cnt_r == 5'(DIV_BITS - 1)) state_nxt = S_UPD;
      S_UPD: begin
        if (can && (cnt_r == ((cmd_r == CMD_BEGIN) ? 5'd3 : 5'd2))) state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (active_r[idx_r]) state_nxt = S_REL;
        else if (idx_r == 4'd15) state_nxt = (cmd_r == CMD_CONFIG) ? S_CFG : S_IDLE;
      end
      S_REL: begin
        if (can && cnt_r[0]) begin
          if (cmd_r == CMD_END) state_nxt = S_IDLE;
          else if (idx_r == 4'd15) state_nxt = (cmd_r == CMD_CONFIG) ? S_CFG : S_IDLE;
          else state_nxt = S_CLR;
        end
      end
      S_CFG:    if (can && cnt_r == CFG_LAST) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Bend value from the signed quotient, held to 0..16383
  logic [13:0] bend;
  always_comb begin
    if (neg_r) bend = (m_r >= DIV_BITS'(8192)) ? 14'd0 : 14'(14'd8192 - m_r[13:0]);
    else       bend = (m_r >= DIV_BITS'(8191)) ? 14'd16383 : 14'(14'd8192 + m_r[13:0]);
  end

  // Message outputs
  always_comb begin
    emit  = 1'b0;
    elast = 1'b0;
    emsg  = '{status: ST_PRESS, d1: 8'd0, d2: 8'd0, len: LEN_2};
    case (state_r)
      S_OLDOFF: begin
        emit = 1'b1;
        emsg = '{status: ST_NOTE_OFF | {4'b0, ch_r}, d1: {1'b0, note_r[ch_r]},
                 d2: 8'd0, len: LEN_3};
      end
      S_UPD: begin
        emit = 1'b1;
        case (cnt_r[1:0])
          2'd0: emsg = '{status: ST_BEND | {4'b0, ch_r}, d1: {1'b0, bend[6:0]},
                         d2: {1'b0, bend[13:7]}, len: LEN_3};
          2'd1: emsg = '{status: ST_CTRL | {4'b0, ch_r}, d1: CC_TIMBRE,
                         d2: {1'b0, sat127(y_r)}, len: LEN_3};
          2'd2: begin
            emsg  = '{status: ST_PRESS | {4'b0, ch_r}, d1: {1'b0, sat127(z_r)},
                      d2: 8'd0, len: LEN_2};
            elast = (cmd_r == CMD_UPDATE);
          end
          default: begin
            emsg  = '{status: ST_NOTE_ON | {4'b0, ch_r}, d1: {1'b0, note_r[ch_r]},
                      d2: VEL_ON, len: LEN_3};
            elast = 1'b1;
          end
        endcase
      end
      S_REL: begin
        emit = 1'b1;
        if (!cnt_r[0]) begin
          emsg = '{status: ST_PRESS | {4'b0, ch_r}, d1: 8'd0, d2: 8'd0, len: LEN_2};
        end else begin
          emsg  = '{status: ST_NOTE_OFF | {4'b0, ch_r}, d1: {1'b0, note_r[ch_r]},
                    d2: 8'd0, len: LEN_3};
          elast = (cmd_r == CMD_END) ||
                  ((cmd_r == CMD_CLEAR) && (((active_r >> ch_r) >> 1) == 16'd0));
        end
      end
      S_CFG: begin
        emit  = 1'b1;
        emsg  = cfg_msg(cnt_r, lzs_r, br_r);
        elast = (cnt_r == CFG_LAST);
      end
      default: emit = 1'b0;
    endcase
  end

  // Allocation and divider set-up
  logic [3:0]  aptr, ach;
  logic [8:0]  xint;
  logic [6:0]  nt;
  logic [6:0]  br_eff;
  logic signed [17:0] dx;
  logic signed [24:0] num;
  logic [24:0] mag;
  logic [8:0]  rem_sh;

  always_comb begin
    aptr   = zone_r ? uptr_r : lptr_r;
    ach    = (aptr < zf || aptr > zl) ? zf : aptr;
    xint   = x_r[16:8];
    nt     = x_r[16] ? 7'd0 : ((xint > 9'd127) ? 7'd127 : xint[6:0]);
    br_eff = (br_r == 7'd0) ? 7'd1 : br_r;
    dx     = $signed({x_r[16], x_r}) - $signed({3'b0, note_r[ch_r], 8'b0});
    num    = $signed({dx[17], dx, 6'b0}) + $signed({18'b0, br_eff});
    mag    = num[24] ? 25'(-num + $signed({17'b0, br_eff, 1'b0}) - 25'sd1) : 25'(num);
    rem_sh = {rem_r[7:0], m_r[DIV_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      lptr_r      <= 4'd1;
      uptr_r      <= 4'd0;
      lzs_r       <= 4'd15;
      br_r        <= 7'd48;
    end else begin
      state_r <= state_nxt;
      if (emit && can) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2]) br_r <= cfg_pwdata[6:0];
        else lzs_r <= cfg_pwdata[3:0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && (in_cmd == CMD_CLEAR || in_cmd == CMD_CONFIG)) begin
            lptr_r <= (lzs_r != 4'd0) ? 4'd1 : 4'd0;
            uptr_r <= (lzs_r < 4'd14) ? lzs_r + 4'd1 : 4'd0;
          end
        end
        S_OLDOFF: if (can) active_r[ch_r] <= 1'b0;
        S_ALLOC: begin
          if (zone_r) uptr_r <= (ach == zl) ? zf : ach + 4'd1;
          else lptr_r <= (ach == zl) ? zf : ach + 4'd1;
          active_r[ach] <= 1'b1;
        end
        S_REL: if (can && cnt_r[0]) active_r[ch_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload and datapath, no reset
  always_ff @(posedge clk) begin
    if (emit && can) begin
      omsg_r  <= emsg;
      otag_r  <= tag_r;
      olast_r <= elast;
    end
    case (state_r)
      S_IDLE: begin
        cmd_r  <= in_cmd;
        zone_r <= in_zone;
        id_r   <= TOUCH_ID_BITS'(in_tdata[15:0]);
        x_r    <= $signed(in_tdata[32:16]);
        y_r    <= in_tdata[48:33];
        z_r    <= in_tdata[64:49];
        tag_r  <= in_tdata[96:65];
        cnt_r  <= 5'd0;
        idx_r  <= (in_cmd == CMD_CLEAR || in_cmd == CMD_CONFIG) ? 4'd0 : in_zf;
      end
      S_FIND: begin
        ch_r  <= idx_r;
        idx_r <= idx_r + 4'd1;
      end
      S_ALLOC: begin
        ch_r         <= ach;
        touch_r[ach] <= id_r;
        note_r[ach]  <= nt;
      end
      S_DSET: begin
        m_r   <= mag[DIV_BITS-1:0];
        neg_r <= num[24];
        rem_r <= 9'd0;
        dvs_r <= {br_eff, 1'b0};
        cnt_r <= 5'd0;
      end
      S_DIV: begin
        // one restoring step per cycle, quotient shifts in behind the dividend
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= rem_sh - {1'b0, dvs_r};
          m_r   <= {m_r[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          m_r   <= {m_r[DIV_BITS-2:0], 1'b0};
        end
        cnt_r <= (cnt_r == 5'(DIV_BITS - 1)) ? 5'd0 : cnt_r + 5'd1;
      end
      S_UPD, S_CFG: if (can) cnt_r <= (state_nxt == S_IDLE) ? 5'd0 : cnt_r + 5'd1;
      S_CLR: begin
        ch_r  <= idx_r;
        cnt_r <= 5'd0;
        if (!active_r[idx_r]) idx_r <= idx_r + 4'd1;
      end
      S_REL: begin
        if (can) begin
          cnt_r <= cnt_r[0] ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r[0]) idx_r <= idx_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, otag_r, omsg_r.len, omsg_r.d2, omsg_r.d1, omsg_r.status};
  assign out_tlast  = olast_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {25'b0, br_r} : {28'b0, lzs_r};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_idle_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(active_r)) else $error("channel table moved while idle");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < {1'b0, dvs_r}) else $error("divider remainder overflow");

endmodule
